/* rtl/core/tvvs_pkg.sv */
// shared widths, register map, defaults and control types for the trade
// volume statistics core; no dependencies
package tvvs_pkg;

  localparam int PRICE_W   = 24;
  localparam int VOL_W     = 16;
  localparam int PROD_W    = PRICE_W + VOL_W;
  localparam int VSUM_W    = 26;
  localparam int NSUM_W    = 50;
  localparam int CNT_W     = 11;
  localparam int RANK_W    = 3;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  localparam int TOP_COUNT_DEF  = 5;
  localparam int MAX_TRADES_DEF = 1024;

  localparam logic [PRICE_W-1:0] THRESHOLD_RESET = 24'd1005000;

  // register index, taken from paddr[2]
  localparam logic REG_THRESHOLD = 1'b0;

  typedef struct packed {
    logic capture;   // latch a new trade and its product
    logic update;    // fold the latched trade into the set
    logic clear;     // start a new set
  } acc_ctl_t;

endpackage

/* rtl/core/tvvs_div.sv */
// iterative restoring divider: 50-bit notional by 26-bit volume, 24-bit
// saturated quotient, one quotient bit per cycle; uses tvvs_pkg
module tvvs_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [tvvs_pkg::NSUM_W-1:0]   num,
  input  logic [tvvs_pkg::VSUM_W-1:0]   den,
  output logic                          done,
  output logic [tvvs_pkg::PRICE_W-1:0]  quo
);
  import tvvs_pkg::*;

  localparam int ITER_W = $clog2(PRICE_W + 1);

  logic                run;
  logic [ITER_W-1:0]   iter;
  logic [VSUM_W-1:0]   rem;
  logic [VSUM_W:0]     trial;
  logic                fits;

  // shift in the next numerator bit, which sits at the top of quo
  assign trial = {rem, quo[PRICE_W-1]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (den == '0) begin
          done <= 1'b1;
        end else if (num >= {den, {PRICE_W{1'b0}}}) begin
          done <= 1'b1;
        end else begin
          run  <= 1'b1;
          iter <= ITER_W'(PRICE_W);
        end
      end else if (run) begin
        iter <= iter - 1'b1;
        if (iter == ITER_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quo doubles as the low numerator bits on the way in
  always_ff @(posedge clk) begin
    if (start) begin
      if (den == '0) begin
        quo <= '0;
      end else if (num >= {den, {PRICE_W{1'b0}}}) begin
        quo <= '1;
      end else begin
        rem <= num[NSUM_W-1:PRICE_W];
        quo <= num[PRICE_W-1:0];
      end
    end else if (run) begin
      rem <= fits ? VSUM_W'(trial - {1'b0, den}) : trial[VSUM_W-1:0];
      quo <= {quo[PRICE_W-2:0], fits};
    end
  end

endmodule

/* rtl/core/tvvs_accum.sv */
// per-set accumulators and the sorted top-volume list; one trade folded in
// per update; uses tvvs_pkg
module tvvs_accum #(
  parameter int TOP_COUNT  = tvvs_pkg::TOP_COUNT_DEF,
  parameter int MAX_TRADES = tvvs_pkg::MAX_TRADES_DEF,
  parameter int KW         = $clog2(TOP_COUNT + 1)
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  tvvs_pkg::acc_ctl_t                           ctl,
  input  logic [tvvs_pkg::PRICE_W-1:0]                 price,
  input  logic [tvvs_pkg::VOL_W-1:0]                   vol,
  input  logic [tvvs_pkg::PRICE_W-1:0]                 threshold,
  output logic [tvvs_pkg::VSUM_W-1:0]                  volume_sum,
  output logic [tvvs_pkg::NSUM_W-1:0]                  notional_sum,
  output logic [tvvs_pkg::CNT_W-1:0]                   above_tally,
  output logic                                         overflow_seen,
  output logic [KW-1:0]                                kept,
  output logic [TOP_COUNT-1:0][tvvs_pkg::PRICE_W-1:0]  best_prices,
  output logic [TOP_COUNT-1:0][tvvs_pkg::VOL_W-1:0]    best_volumes
);
  import tvvs_pkg::*;

  localparam int TW = $clog2(MAX_TRADES + 1);
  localparam int CW = (TW > KW) ? TW : KW;

  logic [TW-1:0]      trade_tally;
  logic [PRICE_W-1:0] price_q;
  logic [VOL_W-1:0]   vol_q;
  logic [PROD_W-1:0]  product;
  logic               full;
  logic [VSUM_W:0]    vsum_add;
  logic [NSUM_W:0]    nsum_add;

  logic [TOP_COUNT-1:0]              ge;
  logic [TOP_COUNT-1:0]              prev_ge;
  logic [TOP_COUNT-1:0][PRICE_W-1:0] shift_prices;
  logic [TOP_COUNT-1:0][VOL_W-1:0]   shift_volumes;
  logic [TOP_COUNT-1:0][PRICE_W-1:0] best_prices_next;
  logic [TOP_COUNT-1:0][VOL_W-1:0]   best_volumes_next;

  assign full     = trade_tally == TW'(MAX_TRADES);
  assign kept     = (CW'(trade_tally) < CW'(TOP_COUNT)) ? KW'(trade_tally) : KW'(TOP_COUNT);
  assign vsum_add = {1'b0, volume_sum} + (VSUM_W + 1)'(vol_q);
  assign nsum_add = {1'b0, notional_sum} + (NSUM_W + 1)'(product);

  // list is sorted, so ge is a run of ones from entry 0
  always_comb begin
    prev_ge       = '0;
    shift_prices  = best_prices;
    shift_volumes = best_volumes;
    prev_ge[0]    = 1'b1;
    for (int i = 0; i < TOP_COUNT; i++) begin
      ge[i] = (KW'(i) < kept) && (best_volumes[i] >= vol_q);
    end
    for (int i = 1; i < TOP_COUNT; i++) begin
      prev_ge[i]       = ge[i-1];
      shift_prices[i]  = best_prices[i-1];
      shift_volumes[i] = best_volumes[i-1];
    end
    for (int i = 0; i < TOP_COUNT; i++) begin
      priority if (ge[i]) begin
        best_prices_next[i]  = best_prices[i];
        best_volumes_next[i] = best_volumes[i];
      end else if (prev_ge[i]) begin
        best_prices_next[i]  = price_q;
        best_volumes_next[i] = vol_q;
      end else begin
        best_prices_next[i]  = shift_prices[i];
        best_volumes_next[i] = shift_volumes[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      volume_sum    <= '0;
      notional_sum  <= '0;
      above_tally   <= '0;
      trade_tally   <= '0;
      overflow_seen <= 1'b0;
    end else if (ctl.clear) begin
      volume_sum    <= '0;
      notional_sum  <= '0;
      above_tally   <= '0;
      trade_tally   <= '0;
      overflow_seen <= 1'b0;
    end else if (ctl.update) begin
      if (full) begin
        overflow_seen <= 1'b1;
      end else begin
        volume_sum   <= vsum_add[VSUM_W] ? '1 : vsum_add[VSUM_W-1:0];
        notional_sum <= nsum_add[NSUM_W] ? '1 : nsum_add[NSUM_W-1:0];
        trade_tally  <= trade_tally + 1'b1;
        if (price_q > threshold) begin
          above_tally <= above_tally + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      price_q <= price;
      vol_q   <= vol;
      product <= PROD_W'(price) * PROD_W'(vol);
    end
    if (ctl.update && !full) begin
      best_prices  <= best_prices_next;
      best_volumes <= best_volumes_next;
    end
  end

endmodule

/* rtl/core/trade_vwap_top_volume_stats_core.sv */
// trade set statistics core: volume-weighted average price and top volumes
// a trade is taken by accept, then fold-in; the multiplier runs at accept
// set end: busy from accept through fold-in, the one-bit-per-cycle divider (which does
// no iterations if volume is 0 or the quotient saturates) and n results, 1 per cycle
// results cannot be stalled; synchronous reset clears all sums, counts and the
// threshold (to 100.50), the top-volume list is only read where written
module trade_vwap_top_volume_stats_core #(
  parameter int TOP_COUNT  = tvvs_pkg::TOP_COUNT_DEF,
  parameter int MAX_TRADES = tvvs_pkg::MAX_TRADES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tvvs_pkg::APB_AW-1:0]    paddr,
  input  logic [tvvs_pkg::APB_DW-1:0]    pwdata,
  output logic [tvvs_pkg::APB_DW-1:0]    prdata,
  output logic                           pready,
  input  logic                           start,
  input  logic [tvvs_pkg::PRICE_W-1:0]   trade_price,
  input  logic [tvvs_pkg::VOL_W-1:0]     trade_volume,
  input  logic                           set_end,
  output logic                           busy,
  output logic                           result_valid,
  output logic [tvvs_pkg::VSUM_W-1:0]    volume_total,
  output logic [tvvs_pkg::PRICE_W-1:0]   vwap_price,
  output logic [tvvs_pkg::CNT_W-1:0]     above_count,
  output logic [tvvs_pkg::RANK_W-1:0]    rank,
  output logic [tvvs_pkg::PRICE_W-1:0]   ranked_price,
  output logic [tvvs_pkg::VOL_W-1:0]     ranked_volume,
  output logic                           overflow,
  output logic                           last_of_run
);
  import tvvs_pkg::*;

  localparam int KW  = $clog2(TOP_COUNT + 1);
  localparam int KIW = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;

  typedef enum logic [4:0] {
    ST_IDLE      = 5'b00001,
    ST_ACC       = 5'b00010,
    ST_DIV_START = 5'b00100,
    ST_DIV_WAIT  = 5'b01000,
    ST_EMIT      = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [PRICE_W-1:0] threshold;
  logic               cfg_wr;
  logic               accept;
  logic               end_q;
  logic [KIW-1:0]     slot;
  logic [KW-1:0]      n_out;
  logic               div_done;
  logic               last_beat;
  acc_ctl_t           ctl;

  logic [VSUM_W-1:0]                 volume_sum;
  logic [NSUM_W-1:0]                 notional_sum;
  logic [CNT_W-1:0]                  above_tally;
  logic                              overflow_seen;
  logic [KW-1:0]                     kept;
  logic [TOP_COUNT-1:0][PRICE_W-1:0] best_prices;
  logic [TOP_COUNT-1:0][VOL_W-1:0]   best_volumes;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_THRESHOLD) ? APB_DW'(threshold) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
    end else if (cfg_wr && paddr[2] == REG_THRESHOLD) begin
      threshold <= pwdata[PRICE_W-1:0];
    end
  end

  assign busy   = state != ST_IDLE;
  assign accept = start && !busy;

  assign ctl.capture = accept;
  assign ctl.update  = state == ST_ACC;
  assign ctl.clear   = last_beat;

  tvvs_accum #(
    .TOP_COUNT  (TOP_COUNT),
    .MAX_TRADES (MAX_TRADES),
    .KW         (KW)
  ) u_accum (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .price         (trade_price),
    .vol           (trade_volume),
    .threshold     (threshold),
    .volume_sum    (volume_sum),
    .notional_sum  (notional_sum),
    .above_tally   (above_tally),
    .overflow_seen (overflow_seen),
    .kept          (kept),
    .best_prices   (best_prices),
    .best_volumes  (best_volumes)
  );

  tvvs_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == ST_DIV_START),
    .num   (notional_sum),
    .den   (volume_sum),
    .done  (div_done),
    .quo   (vwap_price)
  );

  // an empty set still reports one beat
  assign n_out     = (kept == '0) ? KW'(1) : kept;
  assign last_beat = (state == ST_EMIT) && ((KW'(slot) + KW'(1)) == n_out);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (accept) state_next = ST_ACC;
      ST_ACC:       state_next = end_q ? ST_DIV_START : ST_IDLE;
      ST_DIV_START: state_next = ST_DIV_WAIT;
      ST_DIV_WAIT:  if (div_done) state_next = ST_EMIT;
      ST_EMIT:      if (last_beat) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      end_q <= 1'b0;
      slot  <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        end_q <= set_end;
      end
      if (state == ST_EMIT) begin
        slot <= last_beat ? '0 : slot + 1'b1;
      end
    end
  end

  assign result_valid  = state == ST_EMIT;
  assign volume_total  = volume_sum;
  assign above_count   = above_tally;
  assign rank          = RANK_W'(slot);
  assign ranked_price  = (kept == '0) ? '0 : best_prices[slot];
  assign ranked_volume = (kept == '0) ? '0 : best_volumes[slot];
  assign overflow      = overflow_seen;
  assign last_of_run   = last_beat;

  a_accept_busy : assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted trade did not raise busy");

  a_beats_contiguous : assert property (@(posedge clk) disable iff (rst)
    result_valid && !last_of_run |=> result_valid)
    else $error("result beats of one set were not back to back");

  a_idle_after_last : assert property (@(posedge clk) disable iff (rst)
    result_valid && last_of_run |=> !busy && !result_valid)
    else $error("core did not go idle after the last result");

  a_emit_after_div : assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(div_done))
    else $error("results started without a finished division");

endmodule

/* sim/tb_trade_vwap_top_volume_stats_core.sv */
// self-checking bench for the trade volume statistics core: drives trade sets and
// register writes and checks every result beat against a built-in predictor
// depends on tvvs_pkg and trade_vwap_top_volume_stats_core
`timescale 1ns / 1ps

module tb_trade_vwap_top_volume_stats_core;
  import tvvs_pkg::*;

  localparam int TOP = TOP_COUNT_DEF;
  localparam int MAX_TRADES = MAX_TRADES_DEF;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_TRADES = 445;
  localparam int PRINT_CAP = 20;
  localparam logic [63:0] VSUM_MAX = (64'd1 << VSUM_W) - 1;
  localparam logic [63:0] NSUM_MAX = (64'd1 << NSUM_W) - 1;
  localparam logic [PRICE_W-1:0] PRICE_MAX = '1;
  localparam logic [VOL_W-1:0] VOL_MAX = '1;
  localparam logic [APB_AW-1:0] THRESHOLD_ADDR = {REG_THRESHOLD, 2'b00};
  localparam logic [APB_AW-1:0] SPARE_ADDR = {~REG_THRESHOLD, 2'b00};

  typedef struct packed {
    logic [VSUM_W-1:0]  volume_total;
    logic [PRICE_W-1:0] vwap_price;
    logic [CNT_W-1:0]   above_count;
    logic [RANK_W-1:0]  rank;
    logic [PRICE_W-1:0] ranked_price;
    logic [VOL_W-1:0]   ranked_volume;
    logic               overflow;
    logic               last_of_run;
  } stats_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic [PRICE_W-1:0] trade_price = '0;
  logic [VOL_W-1:0] trade_volume = '0;
  logic set_end = 1'b0;
  logic busy;
  logic result_valid;
  logic [VSUM_W-1:0] volume_total;
  logic [PRICE_W-1:0] vwap_price;
  logic [CNT_W-1:0] above_count;
  logic [RANK_W-1:0] rank;
  logic [PRICE_W-1:0] ranked_price;
  logic [VOL_W-1:0] ranked_volume;
  logic overflow;
  logic last_of_run;

  trade_vwap_top_volume_stats_core uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .trade_price(trade_price), .trade_volume(trade_volume),
    .set_end(set_end), .busy(busy), .result_valid(result_valid),
    .volume_total(volume_total), .vwap_price(vwap_price), .above_count(above_count),
    .rank(rank), .ranked_price(ranked_price), .ranked_volume(ranked_volume),
    .overflow(overflow), .last_of_run(last_of_run)
  );

  always #10 clk = ~clk;

  // predictor state for the set in progress
  logic [PRICE_W-1:0] threshold_now = THRESHOLD_RESET;
  logic [63:0] vol_acc = '0;
  logic [63:0] notional_acc = '0;
  int above_acc = 0;
  int trade_acc = 0;
  logic ovf_acc = 1'b0;
  logic [PRICE_W-1:0] top_price [TOP];
  logic [VOL_W-1:0] top_vol [TOP];

  stats_row_t pending_rows [$];
  stats_row_t row_want;
  int mismatches = 0;
  int rows_checked = 0;
  int trades_sent = 0;
  int sets_closed = 0;
  int threshold_writes = 0;
  int burst_left = 1;
  int quiet_cycles = 0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    if (mismatches < PRINT_CAP)
      $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  task automatic clear_set();
    vol_acc = '0;
    notional_acc = '0;
    above_acc = 0;
    trade_acc = 0;
    ovf_acc = 1'b0;
    for (int k = 0; k < TOP; k++) begin
      top_price[k] = '0;
      top_vol[k] = '0;
    end
  endtask

  // fold one accepted trade into the set; on set end queue the ranked rows
  task automatic fold_trade(input logic [PRICE_W-1:0] price, input logic [VOL_W-1:0] vol,
                            input logic closes);
    int kept;
    int pos;
    int i;
    int n;
    logic [63:0] avg;
    stats_row_t row;
    if (trade_acc >= MAX_TRADES) begin
      ovf_acc = 1'b1;
    end else begin
      kept = (trade_acc < TOP) ? trade_acc : TOP;
      pos = 0;
      // equal volume keeps the earlier trade ahead
      while (pos < kept && top_vol[pos] >= vol) pos++;
      if (pos < TOP) begin
        i = (kept < TOP) ? kept : TOP - 1;
        while (i > pos) begin
          top_price[i] = top_price[i-1];
          top_vol[i] = top_vol[i-1];
          i--;
        end
        top_price[pos] = price;
        top_vol[pos] = vol;
      end
      vol_acc = vol_acc + 64'(vol);
      if (vol_acc > VSUM_MAX) vol_acc = VSUM_MAX;
      notional_acc = notional_acc + 64'(price) * 64'(vol);
      if (notional_acc > NSUM_MAX) notional_acc = NSUM_MAX;
      if (price > threshold_now) above_acc++;
      trade_acc++;
    end
    if (closes) begin
      avg = '0;
      if (vol_acc != 0) begin
        avg = notional_acc / vol_acc;
        if (avg > 64'(PRICE_MAX)) avg = 64'(PRICE_MAX);
      end
      kept = (trade_acc < TOP) ? trade_acc : TOP;
      n = (kept == 0) ? 1 : kept;
      for (int k = 0; k < n; k++) begin
        row.volume_total = vol_acc[VSUM_W-1:0];
        row.vwap_price = avg[PRICE_W-1:0];
        row.above_count = CNT_W'(above_acc);
        row.rank = RANK_W'(k);
        row.ranked_price = (kept == 0) ? '0 : top_price[k];
        row.ranked_volume = (kept == 0) ? '0 : top_vol[k];
        row.overflow = ovf_acc;
        row.last_of_run = (k + 1 == n);
        pending_rows.push_back(row);
      end
      sets_closed++;
      clear_set();
    end
  endtask

  // result checker: the core cannot be held off, so every strobe is one beat
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      rows_checked++;
      if (pending_rows.size() == 0) begin
        report("unexpected beat, rank", 64'(rank), 64'(0));
      end else begin
        row_want = pending_rows.pop_front();
        if (volume_total !== row_want.volume_total)
          report("volume_total", 64'(volume_total), 64'(row_want.volume_total));
        if (vwap_price !== row_want.vwap_price)
          report("vwap_price", 64'(vwap_price), 64'(row_want.vwap_price));
        if (above_count !== row_want.above_count)
          report("above_count", 64'(above_count), 64'(row_want.above_count));
        if (rank !== row_want.rank)
          report("rank", 64'(rank), 64'(row_want.rank));
        if (ranked_price !== row_want.ranked_price)
          report("ranked_price", 64'(ranked_price), 64'(row_want.ranked_price));
        if (ranked_volume !== row_want.ranked_volume)
          report("ranked_volume", 64'(ranked_volume), 64'(row_want.ranked_volume));
        if (overflow !== row_want.overflow)
          report("overflow", 64'(overflow), 64'(row_want.overflow));
        if (last_of_run !== row_want.last_of_run)
          report("last_of_run", 64'(last_of_run), 64'(row_want.last_of_run));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no activity for %0d cycles, %0d rows still pending",
                 WATCHDOG_LIMIT, pending_rows.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic pause_sender();
    int gap;
    gap = $urandom_range(1, 6);
    @(negedge clk);
    start <= 1'b0;
    repeat (gap - 1) @(negedge clk);
    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
  endtask

  task automatic send_trade(input logic [PRICE_W-1:0] price, input logic [VOL_W-1:0] vol,
                            input logic closes);
    @(negedge clk);
    start <= 1'b1;
    trade_price <= price;
    trade_volume <= vol;
    set_end <= closes;
    @(posedge clk);
    while (busy) @(posedge clk);
    fold_trade(price, vol, closes);
    trades_sent++;
    burst_left--;
    if (burst_left <= 0) pause_sender();
  endtask

  // quiet the sender and let every pending beat and any fold-in finish
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr[2] == REG_THRESHOLD) begin
      threshold_now = data[PRICE_W-1:0];
      threshold_writes++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apb_read(input logic [APB_AW-1:0] addr, output logic [APB_DW-1:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    data = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_threshold(input logic [PRICE_W-1:0] value);
    settle();
    apb_write(THRESHOLD_ADDR, APB_DW'(value));
  endtask

  function automatic logic [PRICE_W-1:0] pick_price();
    int p;
    unique case ($urandom_range(0, 9))
      0: return '0;
      1: return PRICE_MAX;
      2, 3, 4, 5: begin
        // hover around the threshold to hit the strict compare
        p = int'(threshold_now) - 2 + int'($urandom_range(0, 4));
        if (p < 0) p = 0;
        if (p > int'(PRICE_MAX)) p = int'(PRICE_MAX);
        return PRICE_W'(p);
      end
      default: return PRICE_W'($urandom_range(0, int'(PRICE_MAX)));
    endcase
  endfunction

  function automatic logic [VOL_W-1:0] pick_volume();
    unique case ($urandom_range(0, 9))
      0: return '0;
      1: return VOL_MAX;
      2, 3, 4: return VOL_W'($urandom_range(0, 3));   // dense ties
      default: return VOL_W'($urandom_range(0, int'(VOL_MAX)));
    endcase
  endfunction

  task automatic test_register_access();
    logic [APB_DW-1:0] rd;
    apb_read(THRESHOLD_ADDR, rd);
    if (rd !== APB_DW'(THRESHOLD_RESET))
      report("threshold after reset", 64'(rd), 64'(THRESHOLD_RESET));
    // upper data bits lie outside the register
    apb_write(THRESHOLD_ADDR, 32'hA5_123456);
    apb_read(THRESHOLD_ADDR, rd);
    if (rd !== 32'h00_123456) report("threshold readback", 64'(rd), 64'(32'h00_123456));
    // a write to an unused address must leave the threshold alone
    apb_write(SPARE_ADDR, 32'h0000_0007);
    apb_read(THRESHOLD_ADDR, rd);
    if (rd !== 32'h00_123456)
      report("threshold after spare write", 64'(rd), 64'(32'h00_123456));
    send_trade(24'h123456, 16'd10, 1'b0);
    send_trade(24'h123457, 16'd20, 1'b0);
    send_trade(24'h000008, 16'd30, 1'b1);
    set_threshold(THRESHOLD_RESET);
  endtask

  task automatic test_directed_sets();
    // single trade with no volume: average falls back to zero
    send_trade('0, '0, 1'b1);
    // single trade at both field maxima
    send_trade(PRICE_MAX, VOL_MAX, 1'b1);
    // fewer trades than kept entries, prices straddling the threshold
    send_trade(PRICE_W'(THRESHOLD_RESET - 1), 16'd1, 1'b0);
    send_trade(THRESHOLD_RESET, 16'd2, 1'b0);
    send_trade(PRICE_W'(THRESHOLD_RESET + 1), 16'd3, 1'b1);
    // ties on volume and more trades than kept entries
    send_trade(24'd1000, 16'd5, 1'b0);
    send_trade(24'd2000, 16'd5, 1'b0);
    send_trade(24'd3000, 16'd9, 1'b0);
    send_trade(24'd4000, 16'd5, 1'b0);
    send_trade(24'd5000, 16'd9, 1'b0);
    send_trade(24'd6000, 16'd0, 1'b0);
    send_trade(24'd7000, 16'd5, 1'b1);
    // descending then a late leader that pushes the tail out
    send_trade(24'd11, 16'd600, 1'b0);
    send_trade(24'd12, 16'd500, 1'b0);
    send_trade(24'd13, 16'd400, 1'b0);
    send_trade(24'd14, 16'd300, 1'b0);
    send_trade(24'd15, 16'd200, 1'b0);
    send_trade(24'd16, 16'd700, 1'b1);
    // zero-volume trades mixed with priced ones
    send_trade(PRICE_MAX, '0, 1'b0);
    send_trade(24'd1, 16'd1, 1'b1);
  endtask

  task automatic test_threshold_extremes();
    set_threshold('0);
    send_trade('0, 16'd10, 1'b0);
    send_trade(24'd1, 16'd20, 1'b1);
    set_threshold(PRICE_MAX);
    send_trade(PRICE_MAX, 16'd10, 1'b0);
    send_trade(PRICE_W'(PRICE_MAX - 1), 16'd20, 1'b1);
  endtask

  task automatic test_random_phases();
    logic [PRICE_W-1:0] levels [5];
    int quota;
    int sent;
    int len;
    levels[0] = THRESHOLD_RESET;
    levels[1] = '0;
    levels[2] = PRICE_MAX;
    levels[3] = PRICE_W'($urandom_range(0, int'(PRICE_MAX)));
    levels[4] = PRICE_W'($urandom_range(0, 4000));
    quota = RANDOM_TRADES / 5;
    for (int ph = 0; ph < 5; ph++) begin
      set_threshold(levels[ph]);
      sent = 0;
      while (sent < quota) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
        for (int k = 0; k < len; k++)
          send_trade(pick_price(), pick_volume(), k == len - 1);
        sent += len;
      end
    end
  endtask

  initial begin
    clear_set();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_register_access();
    test_directed_sets();
    test_threshold_extremes();
    test_random_phases();
    @(negedge clk);
    start <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d trades in %0d sets, %0d result beats checked",
             trades_sent, sets_closed, rows_checked);
    $display("threshold written %0d times, ties and threshold edges included, %0d mismatches",
             threshold_writes, mismatches);
    if (mismatches == 0 && pending_rows.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* trade_vwap_top_volume_stats_core.f */
rtl/core/tvvs_pkg.sv
rtl/core/tvvs_div.sv
rtl/core/tvvs_accum.sv
rtl/core/trade_vwap_top_volume_stats_core.sv
sim/tb_trade_vwap_top_volume_stats_core.sv
